@@ design/wrc_pkg.sv @@
// Shared types and constants for the weak reference count table.
// No dependencies; used by the top level and its checker.
package wrc_pkg;

   typedef enum logic [2:0] {
      CMD_ALLOC = 3'd0,
      CMD_INC   = 3'd1,
      CMD_DEC   = 3'd2,
      CMD_CLEAR = 3'd3,
      CMD_QUERY = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_RANGE     = 2'd2,
      ST_NOT_ALLOC = 2'd3
   } status_type;

   typedef enum logic {
      FSM_IDLE = 1'b0,
      FSM_EXEC = 1'b1
   } fsm_type;

   localparam logic [31:0] ALIVE_WORD = 32'h8000_0000;
   localparam logic [30:0] COUNT_MAX  = 31'h7FFF_FFFF;

endpackage

@@ design/weak_ref_count_table_unit.sv @@
// Weak reference count table: count words, free list threaded through the table.
// Depends on wrc_pkg.
//
//  channel  ports                                   handshake
//  request  req_cmd, req_slot                       start & !busy
//  result   rsp_result_slot, rsp_alive, rsp_count,  rsp_valid, one cycle
//           rsp_released, rsp_status
//
// Each command reads the table word at the accept edge; the
// next edge modifies and writes it back and registers the result.
// busy is high for one cycle, up to that edge; a new command may start on the cycle the
// result is shown. The result cannot be stalled.
// Synchronous reset empties the free list and the high-water mark; table
// words need no clearing, since a word also holds its slot's in-use bit and
// slots at or above the high-water mark count as unallocated.
module weak_ref_count_table_unit #(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_cmd,
   input  logic [9:0]  req_slot,
   output logic        rsp_valid,
   output logic [9:0]  rsp_result_slot,
   output logic        rsp_alive,
   output logic [30:0] rsp_count,
   output logic        rsp_released,
   output logic [1:0]  rsp_status
);

   localparam int AW = $clog2(TABLE_DEPTH);

   // bit 32: slot in use; bits 31..0: count word or free-list link
   logic [32:0] table_mem [TABLE_DEPTH];

   wrc_pkg::fsm_type  state_ff, state_in;
   wrc_pkg::cmd_type  cmd_ff;
   logic [9:0]        slot_ff;
   logic [AW-1:0]     addr_ff;
   logic              range_ok_ff;
   logic [32:0]       rd_word_ff;
   logic [AW-1:0]     free_head_ff, free_head_in;
   logic              free_valid_ff, free_valid_in;
   logic [AW:0]       high_water_ff, high_water_in;

   logic              rsp_valid_ff;
   logic [9:0]        rsp_slot_ff, rsp_slot_in;
   logic              rsp_alive_ff, rsp_alive_in;
   logic [30:0]       rsp_count_ff, rsp_count_in;
   logic              rsp_released_ff, rsp_released_in;
   wrc_pkg::status_type rsp_status_ff, rsp_status_in;

   logic              accept;
   logic [31:0]       slot_ext;
   logic [AW-1:0]     req_addr;
   logic [AW-1:0]     rd_addr;

   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [32:0]       wr_data;
   logic [31:0]       word;
   logic [31:0]       new_word;
   logic [31:0]       alloc_ext;
   logic              slot_ok;

   assign accept   = start && (state_ff == wrc_pkg::FSM_IDLE);
   assign slot_ext = 32'(req_slot);
   assign req_addr = slot_ext[AW-1:0];
   assign rd_addr  = (wrc_pkg::cmd_type'(req_cmd) == wrc_pkg::CMD_ALLOC) ? free_head_ff
                                                                        : req_addr;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= wr_data;
      end
      if (accept) begin
         rd_word_ff <= table_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= wrc_pkg::FSM_IDLE;
         free_head_ff  <= '0;
         free_valid_ff <= 1'b0;
         high_water_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         free_head_ff  <= free_head_in;
         free_valid_ff <= free_valid_in;
         high_water_ff <= high_water_in;
         rsp_valid_ff  <= (state_ff == wrc_pkg::FSM_EXEC);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff      <= wrc_pkg::cmd_type'(req_cmd);
         slot_ff     <= req_slot;
         addr_ff     <= req_addr;
         range_ok_ff <= slot_ext < 32'(TABLE_DEPTH);
      end
      if (state_ff == wrc_pkg::FSM_EXEC) begin
         rsp_slot_ff     <= rsp_slot_in;
         rsp_alive_ff    <= rsp_alive_in;
         rsp_count_ff    <= rsp_count_in;
         rsp_released_ff <= rsp_released_in;
         rsp_status_ff   <= rsp_status_in;
      end
   end

   always_comb begin
      word      = rd_word_ff[31:0];
      new_word  = word;
      alloc_ext = '0;
      slot_ok   = range_ok_ff && ((AW+1)'(addr_ff) < high_water_ff) && rd_word_ff[32];

      state_in        = state_ff;
      free_head_in    = free_head_ff;
      free_valid_in   = free_valid_ff;
      high_water_in   = high_water_ff;
      wr_en           = 1'b0;
      wr_addr         = addr_ff;
      wr_data         = {1'b1, word};
      rsp_slot_in     = slot_ff;
      rsp_alive_in    = 1'b0;
      rsp_count_in    = '0;
      rsp_released_in = 1'b0;
      rsp_status_in   = wrc_pkg::ST_OK;

      unique case (state_ff)
         wrc_pkg::FSM_IDLE: begin
            if (accept) begin
               state_in = wrc_pkg::FSM_EXEC;
            end
         end
         wrc_pkg::FSM_EXEC: begin
            state_in = wrc_pkg::FSM_IDLE;
            if (cmd_ff == wrc_pkg::CMD_ALLOC) begin
               if (free_valid_ff) begin
                  // pop: the head word links to the next free slot
                  wr_addr       = free_head_ff;
                  free_valid_in = word[31];
                  free_head_in  = word[AW-1:0];
                  wr_en         = 1'b1;
               end else if (high_water_ff < (AW+1)'(TABLE_DEPTH)) begin
                  wr_addr       = high_water_ff[AW-1:0];
                  high_water_in = high_water_ff + 1'b1;
                  wr_en         = 1'b1;
               end
               if (wr_en) begin
                  wr_data      = {1'b1, wrc_pkg::ALIVE_WORD};
                  alloc_ext    = 32'(wr_addr);
                  rsp_slot_in  = alloc_ext[9:0];
                  rsp_alive_in = 1'b1;
               end else begin
                  rsp_slot_in   = '0;
                  rsp_status_in = wrc_pkg::ST_FULL;
               end
            end else if (!slot_ok) begin
               rsp_status_in = wrc_pkg::ST_NOT_ALLOC;
            end else begin
               rsp_alive_in = word[31];
               rsp_count_in = word[30:0];
               case (cmd_ff) inside
                  wrc_pkg::CMD_INC: begin
                     if (word[30:0] == wrc_pkg::COUNT_MAX) begin
                        rsp_status_in = wrc_pkg::ST_RANGE;
                     end else begin
                        new_word     = {word[31], word[30:0] + 31'd1};
                        wr_en        = 1'b1;
                        wr_data      = {1'b1, new_word};
                        rsp_count_in = new_word[30:0];
                     end
                  end
                  wrc_pkg::CMD_DEC, wrc_pkg::CMD_CLEAR: begin
                     if (cmd_ff == wrc_pkg::CMD_DEC && word[30:0] == '0) begin
                        rsp_status_in = wrc_pkg::ST_RANGE;
                     end else begin
                        if (cmd_ff == wrc_pkg::CMD_DEC) begin
                           new_word = {word[31], word[30:0] - 31'd1};
                        end else begin
                           new_word = {1'b0, word[30:0]};
                        end
                        wr_en = 1'b1;
                        if (new_word == '0) begin
                           // push the slot onto the free list
                           wr_data         = free_valid_ff ? {2'b01, 31'(free_head_ff)} : '0;
                           free_head_in    = addr_ff;
                           free_valid_in   = 1'b1;
                           rsp_alive_in    = 1'b0;
                           rsp_count_in    = '0;
                           rsp_released_in = 1'b1;
                        end else begin
                           wr_data      = {1'b1, new_word};
                           rsp_alive_in = new_word[31];
                           rsp_count_in = new_word[30:0];
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: begin
            state_in = wrc_pkg::FSM_IDLE;
         end
      endcase
   end

   assign busy            = (state_ff == wrc_pkg::FSM_EXEC);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_slot = rsp_slot_ff;
   assign rsp_alive       = rsp_alive_ff;
   assign rsp_count       = rsp_count_ff;
   assign rsp_released    = rsp_released_ff;
   assign rsp_status      = rsp_status_ff;

endmodule

@@ design/wrc_checker.sv @@
// Port-level checks for the weak reference count table, bound to the top level.
// Depends on wrc_pkg and weak_ref_count_table_unit.
module wrc_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [9:0]  rsp_result_slot,
   input logic        rsp_alive,
   input logic [30:0] rsp_count,
   input logic        rsp_released,
   input logic [1:0]  rsp_status
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted transaction did not raise busy");

   a_busy_result: assert property (@(posedge clock) disable iff (reset)
      busy |=> rsp_valid && !busy)
      else $error("busy cycle not followed by a single result");

   a_released: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_released |->
         !rsp_alive && rsp_count == '0 && rsp_status == wrc_pkg::ST_OK)
      else $error("released slot reported with nonzero word or error");

   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == wrc_pkg::ST_FULL |->
         rsp_result_slot == '0 && !rsp_alive && rsp_count == '0 && !rsp_released)
      else $error("table full result carries data");

   a_not_alloc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == wrc_pkg::ST_NOT_ALLOC |->
         !rsp_alive && rsp_count == '0 && !rsp_released)
      else $error("unallocated slot result carries data");

endmodule

bind weak_ref_count_table_unit wrc_checker u_wrc_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_result_slot (rsp_result_slot),
   .rsp_alive       (rsp_alive),
   .rsp_count       (rsp_count),
   .rsp_released    (rsp_released),
   .rsp_status      (rsp_status)
);
